/* hw/rtl/thrt_pkg.sv */
// Shared constants and the log2 table generator for the thermistor converter.
// No dependencies; imported by the top level.
package thrt_pkg;

   // field and port widths
   localparam int RES_W      = 24;
   localparam int TEMP_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int COEF_W     = 48;
   localparam int TNOM_W     = 18;
   localparam int BETA_W     = 16;

   // ln datapath widths
   localparam int LN_W   = 37;
   localparam int LE_W   = 33;
   localparam int EXP_W  = 5;
   localparam int MANT_W = 31;

   localparam int LOG_TABLE_BITS_DEF = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_USE_BETA = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_R_NOM    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_T_NOM    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_A  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_B  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_C  = 3'd6;

   // fixed-point constants
   localparam logic [31:0] LN2_Q32     = 32'hB17217F8;
   localparam int          K_OFF_Q8    = 69926;
   localparam int          K_OFF_Q14   = 4475290;
   localparam int          F_OFF_Q14   = 524288;
   localparam int          C_CLAMP_SH  = 40;
   localparam int          FAH_BIAS_SH = 45;

   // log2(1 + k/2^bits) in Q32 by truncating bit-serial squaring
   function automatic logic [LE_W-1:0] log_entry(input int unsigned k, input int unsigned bits);
      logic [63:0]     y;
      logic [LE_W-1:0] r;
      r = '0;
      if (k >= (32'd1 << bits)) begin
         r = LE_W'(64'd1 << 32);
      end else begin
         y = (64'd1 << 30) + (64'(k) << (30 - bits));
         for (int i = 31; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
               r[i] = 1'b1;
               y = y >> 1;
            end
         end
      end
      return r;
   endfunction

endpackage

/* hw/rtl/thrt_mul.sv */
// Two-stage unsigned multiplier built from four half-width partial products.
// No dependencies.
module thrt_mul #(
   parameter int A_W = 48,
   parameter int B_W = 48
) (
   input  logic               clock,
   input  logic [A_W-1:0]     op_a,
   input  logic [B_W-1:0]     op_b,
   output logic [A_W+B_W-1:0] prod
);
   localparam int HA  = (A_W + 1) / 2;
   localparam int HB  = (B_W + 1) / 2;
   localparam int P_W = A_W + B_W;

   logic [HA+HB-1:0]             pp_ll_ff;
   logic [HA+B_W-HB-1:0]         pp_lh_ff;
   logic [A_W-HA+HB-1:0]         pp_hl_ff;
   logic [A_W-HA+B_W-HB-1:0]     pp_hh_ff;
   logic [P_W-1:0]               prod_ff;

   // partial products
   always_ff @(posedge clock) begin
      pp_ll_ff <= op_a[HA-1:0] * op_b[HB-1:0];
      pp_lh_ff <= op_a[HA-1:0] * op_b[B_W-1:HB];
      pp_hl_ff <= op_a[A_W-1:HA] * op_b[HB-1:0];
      pp_hh_ff <= op_a[A_W-1:HA] * op_b[B_W-1:HB];
   end

   // recombine
   always_ff @(posedge clock) begin
      prod_ff <= (P_W'(pp_hh_ff) << (HA + HB)) + (P_W'(pp_hl_ff) << HA)
               + (P_W'(pp_lh_ff) << HB) + P_W'(pp_ll_ff);
   end

   assign prod = prod_ff;

endmodule

/* hw/rtl/thrt_div.sv */
// Pipelined restoring divider, two quotient bits per stage, behind a registered input stage.
// No dependencies; NUM_W must be even.
module thrt_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 63
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot
);
   localparam int STEPS = NUM_W / 2;

   logic [DEN_W-1:0] rem_ff [STEPS+1];
   logic [NUM_W-1:0] nq_ff  [STEPS+1];
   logic [DEN_W-1:0] den_ff [STEPS+1];

   // one shift-compare-subtract step; quotient bits enter at the bottom of nq
   function automatic logic [DEN_W+NUM_W-1:0] div_step(input logic [DEN_W-1:0] r,
                                                      input logic [NUM_W-1:0] n,
                                                      input logic [DEN_W-1:0] d);
      logic [DEN_W:0] t;
      logic           ge;
      t  = {r, n[NUM_W-1]};
      ge = (t >= {1'b0, d});
      if (ge) begin
         t = t - {1'b0, d};
      end
      return {t[DEN_W-1:0], n[NUM_W-2:0], ge};
   endfunction

   // input stage
   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      nq_ff[0]  <= num;
      den_ff[0] <= den;
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_stage
      logic [DEN_W+NUM_W-1:0] mid_in;
      logic [DEN_W+NUM_W-1:0] fin_in;

      always_comb begin
         mid_in = div_step(rem_ff[s-1], nq_ff[s-1], den_ff[s-1]);
         fin_in = div_step(mid_in[DEN_W+NUM_W-1:NUM_W], mid_in[NUM_W-1:0], den_ff[s-1]);
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= fin_in[DEN_W+NUM_W-1:NUM_W];
         nq_ff[s]  <= fin_in[NUM_W-1:0];
         den_ff[s] <= den_ff[s-1];
      end
   end

   assign quot = nq_ff[STEPS];

endmodule

/* hw/rtl/thermistor_resistance_to_temperature.sv */
// Thermistor resistance to temperature converter, top level.
// Uses thrt_pkg, thrt_mul and thrt_div.
//
// A resistance word is taken on every cycle that start is high (busy never rises), and its
// kelvin, celsius and fahrenheit result appears for one cycle under rsp_strobe; the
// receiver cannot stall, so results cannot be held off. The pipeline runs through two
// chained restoring dividers at two quotient bits a stage (the beta term and 1/T0 side by
// side, then 1/T), behind a five-stage table ln unit, with the fahrenheit scale by ten done
// by a two-stage reciprocal multiply. The user must see that registers are written only
// while no word is in flight; the block itself does not enforce it.
module thermistor_resistance_to_temperature #(
   parameter int LOG_TABLE_BITS = thrt_pkg::LOG_TABLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [thrt_pkg::RES_W-1:0]             req_resistance_ohms,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [thrt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [thrt_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic                                   rsp_strobe,
   output logic [thrt_pkg::TEMP_W-1:0]            rsp_kelvin,
   output logic signed [thrt_pkg::TEMP_W-1:0]     rsp_celsius,
   output logic signed [thrt_pkg::TEMP_W-1:0]     rsp_fahrenheit,
   output logic                                   rsp_fault
);
   import thrt_pkg::*;

   localparam int K_W   = LOG_TABLE_BITS;
   localparam int TAB_N = (1 << LOG_TABLE_BITS) + 1;
   localparam int SH    = 30 - LOG_TABLE_BITS;

   localparam int DIVB_NUM_W = 58;
   localparam int DIVB_DEN_W = 18;
   localparam int DIVK_NUM_W = 64;
   localparam int DIVK_DEN_W = 63;
   localparam int DIVF_NUM_W = 50;
   localparam int DIVB_LAT   = DIVB_NUM_W / 2 + 1;
   localparam int DIVK_LAT   = DIVK_NUM_W / 2 + 1;
   localparam int F_MUL_LAT  = 2;

   // reciprocal of ten: ceil(2^53 / 10), exact for numerators below 2^49
   localparam int                    F_RECIP_SH = 53;
   localparam logic [DIVF_NUM_W-1:0] F_RECIP    = 50'd900719925474100;

   // pipeline positions
   localparam int C_LN  = 5;
   localparam int C_SH  = C_LN + 7;
   localparam int C_DB  = C_LN + DIVB_LAT;
   localparam int C_SEL = C_DB + 1;
   localparam int C_DK  = C_SEL + DIVK_LAT;
   localparam int C_KC  = C_DK + 1;
   localparam int C_DF  = C_KC + F_MUL_LAT;
   localparam int C_OUT = C_DF + 1;

   localparam int C14_W = C_CLAMP_SH + 2;
   localparam logic signed [63:0] C_HI = 64'sd1 <<< C_CLAMP_SH;
   localparam logic signed [63:0] C_LO = -C_HI;
   localparam logic signed [DIVF_NUM_W:0] F_BIAS = (DIVF_NUM_W + 1)'(10) << FAH_BIAS_SH;
   localparam logic signed [63:0] T_MAX = 64'sd8388607;
   localparam logic signed [63:0] T_MIN = -64'sd8388608;
   localparam logic [63:0]        K_MAX_Q8 = 64'hFFFFFF;

   // configuration registers
   logic                     use_beta_ff;
   logic [BETA_W-1:0]        beta_ff;
   logic [RES_W-1:0]         r_nom_ff;
   logic signed [TNOM_W-1:0] t_nom_ff;
   logic signed [COEF_W-1:0] coeff_a_ff, coeff_b_ff, coeff_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_beta_ff <= 1'b1;
         beta_ff     <= BETA_W'(3950);
         r_nom_ff    <= RES_W'(10000);
         t_nom_ff    <= TNOM_W'(6400);
         coeff_a_ff  <= '0;
         coeff_b_ff  <= '0;
         coeff_c_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_USE_BETA: use_beta_ff <= csr_data[0];
            CSR_BETA:     beta_ff     <= csr_data[BETA_W-1:0];
            CSR_R_NOM:    r_nom_ff    <= csr_data[RES_W-1:0];
            CSR_T_NOM:    t_nom_ff    <= csr_data[TNOM_W-1:0];
            CSR_COEFF_A:  coeff_a_ff  <= csr_data[COEF_W-1:0];
            CSR_COEFF_B:  coeff_b_ff  <= csr_data[COEF_W-1:0];
            CSR_COEFF_C:  coeff_c_ff  <= csr_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // valid line
   logic vld_ff [1:C_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= C_OUT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[1] <= start && !busy;
         for (int i = 2; i <= C_OUT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // log2 table as constants
   logic [LE_W-1:0] log_tab [TAB_N];

   for (genvar g = 0; g < TAB_N; g++) begin : g_tab
      localparam logic [LE_W-1:0] ENTRY = log_entry(g, LOG_TABLE_BITS);
      assign log_tab[g] = ENTRY;
   end

   function automatic logic [EXP_W-1:0] msb_pos(input logic [RES_W-1:0] x);
      logic [EXP_W-1:0] p;
      p = '0;
      for (int i = 1; i < RES_W; i++) begin
         if (x[i]) begin
            p = EXP_W'(i);
         end
      end
      return p;
   endfunction

   function automatic logic [TEMP_W-1:0] sat24(input logic signed [63:0] v);
      logic [TEMP_W-1:0] r;
      if (v > T_MAX) begin
         r = T_MAX[TEMP_W-1:0];
      end else if (v < T_MIN) begin
         r = T_MIN[TEMP_W-1:0];
      end else begin
         r = v[TEMP_W-1:0];
      end
      return r;
   endfunction

   // ln lanes: lane 0 the measured word, lane 1 the nominal resistance
   logic [RES_W-1:0] lx_ff  [2];
   logic [EXP_W-1:0] le_ff  [2];
   logic [EXP_W-1:0] le2_ff [2];
   logic [EXP_W-1:0] le3_ff [2];
   logic [K_W-1:0]   lk_ff  [2];
   logic [SH-1:0]    lr_ff  [2];
   logic [SH-1:0]    lr2_ff [2];
   logic [LE_W-1:0]  lt0_ff [2];
   logic [LE_W-1:0]  ldf_ff [2];
   logic [31:0]      lf_ff  [2];
   logic [LN_W-1:0]  lnr_ff [2];

   always_ff @(posedge clock) begin
      lx_ff[0] <= req_resistance_ohms;
      lx_ff[1] <= r_nom_ff;
   end

   for (genvar ln = 0; ln < 2; ln++) begin : g_ln
      logic [EXP_W-1:0]     e_in;
      logic [MANT_W-1:0]    mant_in;
      logic [K_W:0]         k0_in, k1_in;
      logic [LE_W+SH-1:0]   ip_in;
      logic [LE_W-1:0]      f_in;
      logic [63:0]          fl_in;

      always_comb begin
         e_in    = msb_pos(lx_ff[ln]);
         mant_in = MANT_W'(lx_ff[ln]) << (EXP_W'(30) - e_in);
         k0_in   = {1'b0, lk_ff[ln]};
         k1_in   = {1'b0, lk_ff[ln]} + 1'b1;
         ip_in   = ldf_ff[ln] * lr2_ff[ln];
         f_in    = lt0_ff[ln] + ip_in[LE_W+SH-1:SH];
         fl_in   = lf_ff[ln] * LN2_Q32;
      end

      always_ff @(posedge clock) begin
         // leading one and mantissa split
         le_ff[ln]  <= e_in;
         lk_ff[ln]  <= mant_in[29:SH];
         lr_ff[ln]  <= mant_in[SH-1:0];
         // table pair
         le2_ff[ln] <= le_ff[ln];
         lr2_ff[ln] <= lr_ff[ln];
         lt0_ff[ln] <= log_tab[k0_in];
         ldf_ff[ln] <= log_tab[k1_in] - log_tab[k0_in];
         // interpolation
         le3_ff[ln] <= le2_ff[ln];
         lf_ff[ln]  <= f_in[31:0];
         // scale by ln2
         lnr_ff[ln] <= (LN_W'(le3_ff[ln]) * LN_W'(LN2_Q32)) + LN_W'(fl_in[63:32]);
      end
   end

   // zero-resistance flag line
   logic rz_ff [1:C_DB];

   always_ff @(posedge clock) begin
      rz_ff[1] <= (req_resistance_ohms == '0);
      for (int i = 2; i <= C_DB; i++) begin
         rz_ff[i] <= rz_ff[i-1];
      end
   end

   // beta path: (ln R - ln R0)/B and 1/T0
   logic signed [LN_W:0]    ln_d_in;
   logic [LN_W-1:0]         ln_mag_in;
   logic signed [19:0]      t0k_in;
   logic                    t0_pos_in;
   logic [DIVB_NUM_W-1:0]   numq_in, numi_in, divq, divi;
   logic                    dn_ff [C_LN+1:C_DB];

   always_comb begin
      ln_d_in   = signed'({1'b0, lnr_ff[0]}) - signed'({1'b0, lnr_ff[1]});
      ln_mag_in = ln_d_in[LN_W] ? LN_W'(-ln_d_in) : ln_d_in[LN_W-1:0];
      numq_in   = DIVB_NUM_W'({ln_mag_in, 16'b0}) + DIVB_NUM_W'(beta_ff[BETA_W-1:1]);
      t0k_in    = 20'(t_nom_ff) + 20'(K_OFF_Q8);
      t0_pos_in = !t0k_in[19] && (t0k_in != '0);
      numi_in   = (DIVB_NUM_W'(1) << 56) + DIVB_NUM_W'(t0k_in[17:1]);
   end

   thrt_div #(.NUM_W(DIVB_NUM_W), .DEN_W(DIVB_DEN_W)) u_div_beta (
      .clock (clock),
      .num   (numq_in),
      .den   (DIVB_DEN_W'(beta_ff)),
      .quot  (divq)
   );

   thrt_div #(.NUM_W(DIVB_NUM_W), .DEN_W(DIVB_DEN_W)) u_div_t0 (
      .clock (clock),
      .num   (numi_in),
      .den   (t0k_in[17:0]),
      .quot  (divi)
   );

   always_ff @(posedge clock) begin
      dn_ff[C_LN+1] <= ln_d_in[LN_W];
      for (int i = C_LN + 2; i <= C_DB; i++) begin
         dn_ff[i] <= dn_ff[i-1];
      end
   end

   // steinhart-hart path: powers of ln R and coefficient products
   logic [LN_W-1:0]   lnrd_ff [C_LN+1:C_LN+4];
   logic [73:0]       p_l2;
   logic [78:0]       p_l3;
   logic [94:0]       p_c;
   logic [84:0]       p_b;
   logic [COEF_W-1:0] b_mag_in, c_mag_in;
   logic signed [63:0] sb_in, sc_in;
   logic signed [63:0] shd_ff [C_SH:C_DB];

   always_comb begin
      b_mag_in = coeff_b_ff[COEF_W-1] ? COEF_W'(-coeff_b_ff) : COEF_W'(coeff_b_ff);
      c_mag_in = coeff_c_ff[COEF_W-1] ? COEF_W'(-coeff_c_ff) : COEF_W'(coeff_c_ff);
      sb_in    = coeff_b_ff[COEF_W-1] ? -signed'(64'(p_b[84:32])) : signed'(64'(p_b[84:32]));
      sc_in    = coeff_c_ff[COEF_W-1] ? -signed'(64'(p_c[94:32])) : signed'(64'(p_c[94:32]));
   end

   always_ff @(posedge clock) begin
      lnrd_ff[C_LN+1] <= lnr_ff[0];
      for (int i = C_LN + 2; i <= C_LN + 4; i++) begin
         lnrd_ff[i] <= lnrd_ff[i-1];
      end
   end

   thrt_mul #(.A_W(LN_W), .B_W(LN_W)) u_mul_l2 (
      .clock (clock),
      .op_a  (lnr_ff[0]),
      .op_b  (lnr_ff[0]),
      .prod  (p_l2)
   );

   thrt_mul #(.A_W(42), .B_W(LN_W)) u_mul_l3 (
      .clock (clock),
      .op_a  (p_l2[73:32]),
      .op_b  (lnrd_ff[C_LN+2]),
      .prod  (p_l3)
   );

   thrt_mul #(.A_W(COEF_W), .B_W(47)) u_mul_c (
      .clock (clock),
      .op_a  (c_mag_in),
      .op_b  (p_l3[78:32]),
      .prod  (p_c)
   );

   thrt_mul #(.A_W(COEF_W), .B_W(LN_W)) u_mul_b (
      .clock (clock),
      .op_a  (b_mag_in),
      .op_b  (lnrd_ff[C_LN+4]),
      .prod  (p_b)
   );

   always_ff @(posedge clock) begin
      shd_ff[C_SH] <= 64'(coeff_a_ff) + sb_in + sc_in;
      for (int i = C_SH + 1; i <= C_DB; i++) begin
         shd_ff[i] <= shd_ff[i-1];
      end
   end

   // select 1/T and flag faults
   logic signed [63:0] inv_b_in, inv_sel_in;
   logic               flt_in;
   logic signed [63:0] inv_t_ff;
   logic               fk_ff [C_SEL:C_DF];

   always_comb begin
      inv_b_in   = dn_ff[C_DB] ? signed'(64'(divi)) - signed'(64'(divq))
                               : signed'(64'(divi)) + signed'(64'(divq));
      inv_sel_in = use_beta_ff ? inv_b_in : shd_ff[C_DB];
      flt_in     = rz_ff[C_DB] || (inv_sel_in <= 0)
                || (use_beta_ff && ((beta_ff == '0) || (r_nom_ff == '0) || !t0_pos_in));
   end

   always_ff @(posedge clock) begin
      inv_t_ff      <= inv_sel_in;
      fk_ff[C_SEL]  <= flt_in;
      for (int i = C_SEL + 1; i <= C_DF; i++) begin
         fk_ff[i] <= fk_ff[i-1];
      end
   end

   // T = 2^62 / (1/T), rounded
   logic [DIVK_NUM_W-1:0] k14;

   thrt_div #(.NUM_W(DIVK_NUM_W), .DEN_W(DIVK_DEN_W)) u_div_k (
      .clock (clock),
      .num   ((DIVK_NUM_W'(1) << 62) + DIVK_NUM_W'(inv_t_ff[62:1])),
      .den   (inv_t_ff[62:0]),
      .quot  (k14)
   );

   // kelvin in Q8, and celsius clamped in Q14 then rounded to Q8
   logic [63:0]             kr_in;
   logic signed [63:0]      cd_in;
   logic signed [C14_W-1:0] c14_ff;
   logic [TEMP_W-1:0]       kel_ff [C_KC:C_DF];
   logic [TEMP_W-1:0]       cel_ff [C_KC+1:C_DF];
   logic signed [C14_W-1:0] cr_in;

   always_comb begin
      kr_in = (k14 + 64'd32) >> 6;
      cd_in = signed'(k14) - 64'sd4475290;
      cr_in = (c14_ff + C14_W'(32)) >>> 6;
   end

   always_ff @(posedge clock) begin
      kel_ff[C_KC] <= (kr_in > K_MAX_Q8) ? K_MAX_Q8[TEMP_W-1:0] : kr_in[TEMP_W-1:0];
      if (cd_in > C_HI) begin
         c14_ff <= C14_W'(C_HI);
      end else if (cd_in < C_LO) begin
         c14_ff <= C14_W'(C_LO);
      end else begin
         c14_ff <= C14_W'(cd_in);
      end
      cel_ff[C_KC+1] <= sat24(64'(cr_in));
      for (int i = C_KC + 1; i <= C_DF; i++) begin
         kel_ff[i] <= kel_ff[i-1];
      end
      for (int i = C_KC + 2; i <= C_DF; i++) begin
         cel_ff[i] <= cel_ff[i-1];
      end
   end

   // fahrenheit: floor((18*C + 5)/10), biased positive, divided by ten through a reciprocal
   logic signed [DIVF_NUM_W:0] fx_c_in, fx_in;
   logic [2*DIVF_NUM_W-1:0]    f_prod;
   logic [DIVF_NUM_W-1:0]      fq;

   always_comb begin
      fx_c_in = (DIVF_NUM_W + 1)'(c14_ff);
      fx_in   = (fx_c_in <<< 4) + (fx_c_in <<< 1) + (DIVF_NUM_W + 1)'(5) + F_BIAS;
      fq      = DIVF_NUM_W'(f_prod[2*DIVF_NUM_W-1:F_RECIP_SH]);
   end

   thrt_mul #(.A_W(DIVF_NUM_W), .B_W(DIVF_NUM_W)) u_mul_f (
      .clock (clock),
      .op_a  (fx_in[DIVF_NUM_W-1:0]),
      .op_b  (F_RECIP),
      .prod  (f_prod)
   );

   // output word
   logic signed [63:0] f14_in, fr_in;
   logic [TEMP_W-1:0]  okel_ff, ocel_ff, ofah_ff;
   logic               oflt_ff;

   always_comb begin
      f14_in = signed'(64'(fq)) - (64'sd1 <<< FAH_BIAS_SH) + 64'(F_OFF_Q14);
      fr_in  = (f14_in + 64'sd32) >>> 6;
   end

   always_ff @(posedge clock) begin
      oflt_ff <= fk_ff[C_DF];
      okel_ff <= fk_ff[C_DF] ? '0 : kel_ff[C_DF];
      ocel_ff <= fk_ff[C_DF] ? '0 : cel_ff[C_DF];
      ofah_ff <= fk_ff[C_DF] ? '0 : sat24(fr_in);
   end

   assign rsp_strobe     = vld_ff[C_OUT];
   assign rsp_kelvin     = okel_ff;
   assign rsp_celsius    = ocel_ff;
   assign rsp_fahrenheit = ofah_ff;
   assign rsp_fault      = oflt_ff;

endmodule
